/* design/iid_pkg.sv */
package iid_pkg;

  localparam int MaxComponentIndex = 15;
  localparam int CompW = 5;

  localparam logic [10:0] F_CLAMP = 11'h001;
  localparam logic [10:0] F_DERIV = 11'h002;
  localparam logic [10:0] F_LOD   = 11'h004;
  localparam logic [10:0] F_BIAS  = 11'h008;
  localparam logic [10:0] F_LZ    = 11'h010;
  localparam logic [10:0] F_CMP   = 11'h020;
  localparam logic [10:0] F_OFF   = 11'h040;
  localparam logic [10:0] F_CD    = 11'h080;
  localparam logic [10:0] F_ADJ   = 11'h100;
  localparam logic [10:0] F_GH    = 11'h200;
  localparam logic [10:0] F_A16   = 11'h400;

  localparam logic [5:0]  ENC_IMAGE    = 6'h3C;
  localparam logic [31:0] RSV_W0       = 32'h0003_50C0;
  localparam logic [31:0] RSV_W1       = 32'h3C00_0000;
  localparam logic [7:0]  SCALAR_LIMIT = 8'd106;

  localparam logic [7:0] OPC_LOAD_MIP     = 8'h01;
  localparam logic [7:0] OPC_LOAD         = 8'h00;
  localparam logic [7:0] OPC_STORE        = 8'h08;
  localparam logic [7:0] OPC_STORE_MIP    = 8'h09;
  localparam logic [7:0] OPC_GET_RESINFO  = 8'h0E;
  localparam logic [7:0] OPC_GET_LOD      = 8'h60;

  typedef enum logic [4:0] {
    ST_OK, ST_SHORT, ST_ENCODING, ST_RESERVED, ST_LENGTH, ST_ALIGN, ST_OPCODE,
    ST_LAYOUT, ST_LOD_CONFLICT, ST_MSAA, ST_DMASK, ST_D16, ST_COMPONENTS,
    ST_NSA, ST_VADDR, ST_VDATA, ST_DESCRIPTOR, ST_SAMPLER
  } status_t;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [2:0]  words_available;
    logic [31:0] program_counter;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  status;
    logic [4:0]  op_kind;
    logic [7:0]  opcode_id;
    logic [2:0]  dimension;
    logic [10:0] sample_flags;
    logic [4:0]  address_components;
    logic [3:0]  data_mask;
    logic [2:0]  data_components;
    logic [2:0]  data_dwords;
    logic [2:0]  word_count;
    logic [31:0] register_numbers;
    logic [4:0]  control_bits;
  } out_item_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  kind;
    logic [10:0] flags;
  } op_info_t;

  function automatic op_info_t op_lookup(input logic [7:0] opc);
    op_info_t r;
    r = '{found: 1'b1, kind: 5'd0, flags: 11'd0};
    case (opc)
      8'h20: r.flags = '0;
      8'h21: r.flags = F_CLAMP;
      8'h22: r.flags = F_DERIV;
      8'h23: r.flags = F_DERIV | F_CLAMP;
      8'h24: r.flags = F_LOD;
      8'h25: r.flags = F_BIAS;
      8'h26: r.flags = F_BIAS | F_CLAMP;
      8'h27: r.flags = F_LZ;
      8'h28: r.flags = F_CMP;
      8'h29: r.flags = F_CMP | F_CLAMP;
      8'h2a: r.flags = F_CMP | F_DERIV;
      8'h2c: r.flags = F_CMP | F_LOD;
      8'h2d: r.flags = F_CMP | F_BIAS;
      8'h2f: r.flags = F_CMP | F_LZ;
      8'h30: r.flags = F_OFF;
      8'h31: r.flags = F_CLAMP | F_OFF;
      8'h32: r.flags = F_DERIV | F_OFF;
      8'h34: r.flags = F_LOD | F_OFF;
      8'h35: r.flags = F_BIAS | F_OFF;
      8'h37: r.flags = F_LZ | F_OFF;
      8'h38: r.flags = F_CMP | F_OFF;
      8'h68: r.flags = F_DERIV | F_CD;
      8'ha0: r.flags = F_ADJ;
      8'ha1: r.flags = F_CLAMP | F_ADJ;
      8'ha5: r.flags = F_BIAS | F_ADJ;
      8'ha8: r.flags = F_CMP | F_ADJ;
      8'hb0: r.flags = F_OFF | F_ADJ;
      8'h47: begin r.kind = 5'd1; r.flags = F_LZ; end
      8'h48: begin r.kind = 5'd2; r.flags = F_CMP; end
      8'h4f: begin r.kind = 5'd3; r.flags = F_CMP | F_LZ; end
      8'h57: begin r.kind = 5'd4; r.flags = F_LZ | F_OFF; end
      8'h58: begin r.kind = 5'd5; r.flags = F_CMP | F_OFF; end
      8'h5f: begin r.kind = 5'd6; r.flags = F_CMP | F_LZ | F_OFF; end
      8'h61: begin r.kind = 5'd7; r.flags = F_GH; end
      8'h0f: r.kind = 5'd8;
      8'h11: r.kind = 5'd9;
      8'h15: r.kind = 5'd10;
      8'h17: r.kind = 5'd11;
      8'h18: r.kind = 5'd12;
      8'h19: r.kind = 5'd13;
      8'h1a: r.kind = 5'd14;
      8'h00: r.kind = 5'd15;
      8'h01: r.kind = 5'd16;
      8'h08: r.kind = 5'd17;
      8'h09: r.kind = 5'd18;
      8'h0e: r.kind = 5'd19;
      8'h60: r.kind = 5'd20;
      default: r.found = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* design/iid_decode.sv */
module iid_decode (
  input  iid_pkg::in_item_t  item,
  output iid_pkg::out_item_t result
);
  import iid_pkg::*;

  logic [31:0] w0, w1;
  logic [1:0]  nsa;
  logic [2:0]  wc;
  logic [7:0]  opc;
  logic        a16, d16, r128, msaa, smpl, gath, atom;
  logic [2:0]  dim;
  logic [3:0]  dmask;
  logic [7:0]  vaddr, vdata, res, smp;
  op_info_t    info;
  logic [10:0] flags;
  logic [2:0]  coord, grad;
  logic [5:0]  comps;
  logic [2:0]  nlod, nextra, dcomp, ddw;
  logic [32:0] pc_end;
  logic [2:0]  n32;
  logic        has_cmp_last;
  logic [5:0]  adw;
  logic [8:0]  halves;
  status_t     st;

  always_comb begin
    w0 = item.first_word;
    w1 = item.second_word;
    nsa = w0[2:1];
    wc = 3'd2 + {1'b0, nsa};
    opc = {w0[0], w0[24:18]};
    a16 = w1[30];
    d16 = w1[31];
    r128 = w0[15];
    case (w0[5:3])
      3'd5: dim = 3'd3;
      3'd6: dim = 3'd5;
      3'd7: dim = 3'd6;
      default: dim = w0[5:3];
    endcase
    msaa = dim >= 3'd5;
    dmask = w0[11:8];
    vaddr = w1[7:0];
    vdata = w1[15:8];
    res = {1'b0, w1[20:16], 2'b00};
    smp = {1'b0, w1[25:21], 2'b00};
    info = op_lookup(opc);
    smpl = info.found && info.kind == 5'd0;
    gath = info.kind >= 5'd1 && info.kind <= 5'd7;
    atom = info.kind >= 5'd8 && info.kind <= 5'd14;
    flags = info.flags | (a16 ? F_A16 : 11'd0);

    case (dim)
      3'd0: begin coord = 3'd1; grad = 3'd1; end
      3'd1: begin coord = 3'd2; grad = 3'd2; end
      3'd2: begin coord = 3'd3; grad = 3'd3; end
      3'd3: begin coord = 3'd3; grad = 3'd2; end
      3'd4: begin coord = 3'd2; grad = 3'd1; end
      3'd5: begin coord = 3'd3; grad = 3'd0; end
      default: begin coord = 3'd4; grad = 3'd0; end
    endcase

    nlod = 3'(flags[2]) + 3'(flags[3]) + 3'(flags[1]) + 3'(flags[4]);
    nextra = 3'(flags[6]) + 3'(flags[5]) + 3'(flags[3]) + 3'(flags[2]);
    comps = (opc == OPC_GET_RESINFO) ? 6'd1 : 6'(coord);
    if (opc == OPC_LOAD_MIP || opc == OPC_STORE_MIP) comps = comps + 6'd1;
    if (smpl || gath) begin
      comps = comps + 6'(nextra);
      if (flags[1]) comps = comps + 6'({grad, 1'b0});
    end

    // address dwords: without a16 every component is a dword; with a16 the
    // 32-bit extras (offset leading, compare last) each take a whole dword and the
    // 16-bit ones pack two per dword.
    adw = comps;
    if (a16) begin
      n32 = 3'(flags[6]);
      has_cmp_last = 1'b0;
      halves = 9'(comps) - 9'(n32);
      if (flags[5]) begin
        // compare sits after offset and bias; 32-bit, dword aligned
        if (comps > 6'(3'(flags[6]) + 3'(flags[3]))) begin
          has_cmp_last = 1'b1;
          halves = halves - 9'd1;
        end
      end
      if (has_cmp_last) begin
        // bias (16b) before compare occupies a padded dword
        adw = 6'(n32) + (flags[3] ? 6'd1 : 6'd0) + 6'd1 +
              6'((halves - (flags[3] ? 9'd1 : 9'd0) + 9'd1) >> 1);
      end else begin
        adw = 6'(n32) + 6'((halves + 9'd1) >> 1);
      end
    end else begin
      n32 = '0;
      has_cmp_last = 1'b0;
      halves = '0;
    end

    dcomp = gath ? 3'd4 : 3'($countones(dmask));
    ddw = d16 ? 3'((4'(dcomp) + 4'd1) >> 1) : dcomp;
    pc_end = {1'b0, item.program_counter} + 33'({wc, 2'b00}) - 33'd1;

    st = ST_OK;
    if (item.words_available < 3'd2) st = ST_SHORT;
    else if (w0[31:26] != ENC_IMAGE) st = ST_ENCODING;
    else if ((w0 & RSV_W0) != 0 || (w1 & RSV_W1) != 0) st = ST_RESERVED;
    else if (item.words_available < wc) st = ST_LENGTH;
    else if (item.program_counter[1:0] != 2'b00 || pc_end[32]) st = ST_ALIGN;
    else if (!info.found) st = ST_OPCODE;
    else if ((flags & (F_CLAMP | F_CD | F_ADJ)) != 0) st = ST_LAYOUT;
    else if (nlod > 3'd1) st = ST_LOD_CONFLICT;
    else if (msaa && (smpl || gath || opc == OPC_GET_LOD || opc == OPC_LOAD_MIP ||
                      opc == OPC_STORE_MIP)) st = ST_MSAA;
    else if (dmask == 4'd0 || ((gath || atom) && $countones(dmask) != 1)) st = ST_DMASK;
    else if (d16 && !(smpl || gath || opc == OPC_LOAD || opc == OPC_LOAD_MIP ||
                      opc == OPC_STORE || opc == OPC_STORE_MIP)) st = ST_D16;
    else if (comps == 6'd0 || comps > 6'(MaxComponentIndex + 1)) st = ST_COMPONENTS;
    else if (nsa != 2'd0 && adw > 6'd1 + 6'({nsa, 2'b00})) st = ST_NSA;
    else if (nsa == 2'd0 && 9'(adw) > 9'd256 - 9'(vaddr)) st = ST_VADDR;
    else if (9'(ddw) > 9'd256 - 9'(vdata)) st = ST_VDATA;
    else if (res + (r128 ? 8'd4 : 8'd8) > SCALAR_LIMIT ||
             ((smpl || gath || opc == OPC_GET_LOD) && smp + 8'd4 > SCALAR_LIMIT))
      st = ST_DESCRIPTOR;
    else if (smp >= SCALAR_LIMIT) st = ST_SAMPLER;

    result = '0;
    result.status = st;
    if (st == ST_OK) begin
      result.op_kind = info.kind;
      result.opcode_id = opc;
      result.dimension = dim;
      result.sample_flags = flags;
      result.address_components = comps[CompW-1:0];
      result.data_mask = dmask;
      result.data_components = dcomp;
      result.data_dwords = ddw;
      result.word_count = wc;
      result.register_numbers = {smp, res, vaddr, vdata};
      result.control_bits = {r128, d16, a16, w0[25], w0[13]};
    end
  end
endmodule

/* design/image_instruction_decoder_core.sv */
// Image instruction decoder: one instruction per clock while the output is not stalled.
// The incoming item is decoded and checked in one combinational pass and the
// result is captured in an output register; a new item is accepted whenever
// the output register is empty or being drained.
module image_instruction_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iid_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iid_pkg::out_item_t out_data
);
  import iid_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t dec;
  logic      take;

  iid_decode u_dec (.item(in_data), .result(dec));

  assign in_stall = out_valid_r && out_stall;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= dec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule
